FILE: design/skt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants and the key folding function of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;
    localparam int Capacity = 64;
    localparam int KeyBytes = 8;
    localparam int AddrW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);
    // Stored entry: valid flag, value and key.
    localparam int EntryW = 1 + 64 + 64;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_EXISTS  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [0:0] REG_VALUE_BYTES = 1'd0;

    // Cut the key at its first zero byte and fold A-Z to lower case.
    function automatic logic [63:0] canon_key(input logic [63:0] raw);
        logic [63:0] o;
        logic        stop;
        logic [7:0]  b;
        o = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            b = raw[63 - 8 * i -: 8];
            if (b == 8'd0 || i >= KeyBytes) stop = 1'b1;
            if (!stop) begin
                if (b >= 8'h41 && b <= 8'h5A) b = b + 8'h20;
                o[63 - 8 * i -: 8] = b;
            end
        end
        return o;
    endfunction
endpackage

FILE: design/sorted_key_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Sorted key table with lookup, insert and remove by binary search.
// ----------------------------------------------------------------------------
// The table holds up to 64 entries in one single-port RAM, each entry holding
// the folded key, the masked value and a value-valid flag, in ascending key
// order. One item is processed at a time. A binary search runs at most seven
// probes, each an address step and then a compare step, followed by a step
// that sees the range is empty and a step that decides the result. An insert
// then moves entries up one place from the top down, and a remove moves them
// down from the removal point, each moved entry taking a read step and a write
// step through the single RAM port, followed by one write of the new entry on
// insert. The worst case is an insert at the front of a table of 63 entries,
// which moves all 63 of them before the next item can be accepted.
// The result sits in an output register so the next item can be accepted
// while it waits to be taken; a finished item holds in its decision step only
// while the previous result is still waiting.
module sorted_key_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value,
    input  logic        i_value_present,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [6:0]  o_index,
    output logic [6:0]  o_count
);
    import skt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PROBE, S_CMP, S_SH_RD, S_SH_WR, S_PUT, S_DONE
    } t_state;

    t_state            r_state;
    logic [3:0]        r_vbytes;
    logic [1:0]        r_func;
    logic [63:0]       r_key;
    logic [63:0]       r_val;
    logic              r_vp;
    logic [CntW-1:0]   r_lo, r_hi, r_cnt, r_ptr;
    logic              r_found;
    logic              r_ovalid;
    logic [1:0]        r_status;
    logic [6:0]        r_index, r_ocount;

    logic              mem_we;
    logic [AddrW-1:0]  mem_addr;
    logic [EntryW-1:0] mem_wdata, mem_rdata;
    logic [CntW-1:0]   mid;
    logic [63:0]       vmask;
    logic [3:0]        nb;

    assign pready = 1'b1;
    assign prdata = {28'd0, r_vbytes};
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_status = r_status;
    assign o_index = r_index;
    assign o_count = r_ocount;

    assign mid = CntW'((r_lo + r_hi) >> 1);
    assign nb = (r_vbytes > 4'd8) ? 4'd8 : r_vbytes;
    always_comb begin
        vmask = '0;
        for (int i = 0; i < 8; i++) if (4'(i) < nb) vmask[8 * i +: 8] = 8'hFF;
    end

    skt_ram #(.Width(EntryW), .Depth(Capacity)) u_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata)
    );

    always_comb begin
        mem_we = 1'b0;
        mem_addr = mid[AddrW-1:0];
        mem_wdata = mem_rdata;
        case (r_state)
            S_SH_RD: begin
                if (r_func == FUNC_INSERT) mem_addr = AddrW'(r_ptr - 1'b1);
                else mem_addr = AddrW'(r_ptr + 1'b1);
            end
            S_SH_WR: begin
                mem_we = 1'b1;
                mem_addr = r_ptr[AddrW-1:0];
            end
            S_PUT: begin
                mem_we = 1'b1;
                mem_addr = r_lo[AddrW-1:0];
                if (r_vp && nb != 4'd0) mem_wdata = {1'b1, r_val & vmask, r_key};
                else mem_wdata = {1'b0, 64'd0, r_key};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vbytes <= 4'd8;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[1:0] == {REG_VALUE_BYTES, 1'b0})
                r_vbytes <= pwdata[3:0];
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_func <= i_func;
                        r_key <= canon_key(i_key);
                        r_val <= i_value;
                        r_vp <= i_value_present;
                        r_lo <= '0;
                        r_hi <= r_cnt;
                        r_found <= 1'b0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    // Address of mid is on the RAM this cycle.
                    if (r_lo < r_hi) r_state <= S_CMP;
                    else r_state <= S_DONE;
                end
                S_CMP: begin
                    if (mem_rdata[63:0] == r_key) begin
                        r_found <= 1'b1;
                        r_lo <= mid;
                        r_state <= S_DONE;
                    end else begin
                        if (r_key > mem_rdata[63:0]) r_lo <= mid + 1'b1;
                        else r_hi <= mid;
                        r_state <= S_PROBE;
                    end
                end
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    if (r_func == FUNC_INSERT) begin
                        if (r_ptr - 1'b1 == r_lo) r_state <= S_PUT;
                        else begin
                            r_ptr <= r_ptr - 1'b1;
                            r_state <= S_SH_RD;
                        end
                    end else begin
                        if (r_ptr + 1'b1 >= r_cnt) r_state <= S_IDLE;
                        else begin
                            r_ptr <= r_ptr + 1'b1;
                            r_state <= S_SH_RD;
                        end
                    end
                end
                S_PUT: r_state <= S_IDLE;
                S_DONE: begin
                    // Decide the result and start any shift, once the output
                    // register is free or being emptied this cycle.
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_status <= ST_OK;
                        r_index <= 7'(r_lo);
                        r_ocount <= 7'(r_cnt);
                        r_state <= S_IDLE;
                        if (r_func == FUNC_INSERT) begin
                            if (r_found) begin
                                r_status <= ST_EXISTS;
                                r_index <= '0;
                            end else if (r_cnt >= CntW'(Capacity)) begin
                                r_status <= ST_FULL;
                                r_index <= '0;
                            end else begin
                                r_cnt <= r_cnt + 1'b1;
                                r_ocount <= 7'(r_cnt + 1'b1);
                                r_ptr <= r_cnt;
                                r_state <= (r_cnt == r_lo) ? S_PUT : S_SH_RD;
                            end
                        end else if (r_func == FUNC_REMOVE) begin
                            if (!r_found) begin
                                r_status <= ST_MISSING;
                                r_index <= '0;
                            end else begin
                                r_cnt <= r_cnt - 1'b1;
                                r_ocount <= 7'(r_cnt - 1'b1);
                                r_ptr <= r_lo;
                                if (r_lo + 1'b1 < r_cnt) r_state <= S_SH_RD;
                            end
                        end else if (!r_found) begin
                            r_status <= ST_MISSING;
                            r_index <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/skt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
